### rtl/sfid_pkg.sv
// sfid_pkg: constants, types and helper functions for the smallest-free id allocator
// used by sfid_rowstore and smallest_free_id_allocator_top; no dependencies
`default_nettype none

package sfid_pkg;

  // id space and first id handed out by the counter
  localparam int ID_SPACE = 1024;
  localparam int FIRST_ID = 1;

  // fixed field widths of the ports
  localparam int FUNC_W     = 2;
  localparam int ID_FIELD_W = 10;
  localparam int STATUS_W   = 2;

  // bitmap geometry: one ram row holds the in-use and released bits of WORD_BITS ids
  localparam int WORD_BITS  = (ID_SPACE >= 64) ? 32 : ID_SPACE / 4;
  localparam int ROWS       = ID_SPACE / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int IDX_W      = ROW_W + BIT_W;
  localparam int CNT_W      = IDX_W + 1;
  localparam int ROW_DATA_W = 2 * WORD_BITS;

  // function codes
  localparam logic [FUNC_W-1:0] FN_AUTO    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_GIVEN   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd3;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [BIT_W-1:0]      bit_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ROW_DATA_W-1:0] row_data_t;
  typedef logic [ID_FIELD_W-1:0] id_field_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RMW_RD,
    S_RMW_CHK
  } state_t;

  typedef enum logic {
    OP_CLAIM,
    OP_RELEASE
  } op_t;

  // one access to the bitmap row store
  typedef struct packed {
    logic      rd;
    logic      we;
    row_t      row;
    row_data_t wdata;
  } row_req_t;

  // position of the lowest set bit, binary search over halves
  function automatic bit_t lowest_set(word_t w);
    word_t v;
    word_t mask;
    bit_t  pos;
    v   = w;
    pos = '0;
    for (int s = BIT_W - 1; s >= 0; s--) begin
      mask = word_t'((64'd1 << (1 << s)) - 64'd1);
      if ((v & mask) == '0) begin
        pos[s] = 1'b1;
        v      = v >> (1 << s);
      end
    end
    return pos;
  endfunction

  // port id field to internal index
  function automatic idx_t to_idx(id_field_t id);
    logic [16:0] w;
    w = 17'(id);
    return w[IDX_W-1:0];
  endfunction

  // internal index to port id field
  function automatic id_field_t to_field(idx_t idx);
    logic [16:0] w;
    w = 17'(idx);
    return w[ID_FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/smallest_free_id_allocator_top.sv
// smallest_free_id_allocator_top: sequencer and datapath of the id allocator
// depends on sfid_pkg and sfid_rowstore
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+------------------------------------
//  request  | func, given_id           | beat taken when start & !busy
//  result   | result_id, status        | beat shown for one cycle with done
//
// release and explicit requests keep busy high through a row read and a row update.
// automatic requests scan the bitmap ram row by row, a read and a check for each row, up to
// the row of the lowest released id; with none, the counter id gets a row read and update.
// range failures and the unused code give their beat the cycle after the request.
// done rises in the cycle in which busy falls; a new request may be taken in that cycle.
// rst clears the maps at once through per-row valid flags; the receiver cannot stall.
`default_nettype none

module smallest_free_id_allocator_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [sfid_pkg::FUNC_W-1:0]   func,
  input  wire logic [sfid_pkg::ID_FIELD_W-1:0] given_id,
  output logic                               done,
  output logic [sfid_pkg::ID_FIELD_W-1:0]    result_id,
  output logic [sfid_pkg::STATUS_W-1:0]      status
);

  sfid_pkg::state_t    state, state_next;
  sfid_pkg::op_t       op, op_next;
  sfid_pkg::idx_t      cur_idx, cur_idx_next;
  sfid_pkg::row_t      scan_row, scan_row_next;
  sfid_pkg::cnt_t      counter, counter_next;
  logic                done_next;
  sfid_pkg::id_field_t result_id_next;
  logic [sfid_pkg::STATUS_W-1:0] status_next;

  sfid_pkg::row_req_t  req;
  sfid_pkg::row_data_t row_data;
  sfid_pkg::word_t     rel, used;
  sfid_pkg::bit_t      scan_bit, cur_bit;
  sfid_pkg::word_t     scan_oh, cur_oh;
  logic                id_out_of_range;

  sfid_rowstore u_rowstore (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (row_data)
  );

  assign rel      = row_data[sfid_pkg::ROW_DATA_W-1:sfid_pkg::WORD_BITS];
  assign used     = row_data[sfid_pkg::WORD_BITS-1:0];
  assign scan_bit = sfid_pkg::lowest_set(rel);
  assign scan_oh  = sfid_pkg::word_t'(1) << scan_bit;
  assign cur_bit  = cur_idx[sfid_pkg::BIT_W-1:0];
  assign cur_oh   = sfid_pkg::word_t'(1) << cur_bit;
  assign id_out_of_range = 17'(given_id) >= 17'(sfid_pkg::ID_SPACE);
  assign busy     = (state != sfid_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sfid_pkg::S_IDLE;
      counter  <= sfid_pkg::cnt_t'(sfid_pkg::FIRST_ID);
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      counter  <= counter_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    cur_idx   <= cur_idx_next;
    scan_row  <= scan_row_next;
    result_id <= result_id_next;
    status    <= status_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    cur_idx_next   = cur_idx;
    scan_row_next  = scan_row;
    counter_next   = counter;
    done_next      = 1'b0;
    result_id_next = result_id;
    status_next    = status;
    req.rd         = 1'b0;
    req.we         = 1'b0;
    req.row        = scan_row;
    req.wdata      = row_data;

    case (state)
      sfid_pkg::S_IDLE: begin
        if (start) begin
          op_next       = sfid_pkg::OP_CLAIM;
          cur_idx_next  = sfid_pkg::to_idx(given_id);
          scan_row_next = '0;
          case (func)
            sfid_pkg::FN_AUTO: begin
              state_next = sfid_pkg::S_SCAN_RD;
            end
            sfid_pkg::FN_GIVEN: begin
              // id zero falls back to an automatic request
              if (given_id == '0) begin
                state_next = sfid_pkg::S_SCAN_RD;
              end else if (id_out_of_range) begin
                done_next      = 1'b1;
                result_id_next = '0;
                status_next    = sfid_pkg::ST_EXHAUSTED;
              end else begin
                state_next = sfid_pkg::S_RMW_RD;
              end
            end
            sfid_pkg::FN_RELEASE: begin
              op_next = sfid_pkg::OP_RELEASE;
              if (id_out_of_range) begin
                done_next      = 1'b1;
                result_id_next = '0;
                status_next    = sfid_pkg::ST_NOT_IN_USE;
              end else begin
                state_next = sfid_pkg::S_RMW_RD;
              end
            end
            default: begin
              done_next      = 1'b1;
              result_id_next = '0;
              status_next    = sfid_pkg::ST_OK;
            end
          endcase
        end
      end

      sfid_pkg::S_SCAN_RD: begin
        req.rd     = 1'b1;
        req.row    = scan_row;
        state_next = sfid_pkg::S_SCAN_CHK;
      end

      sfid_pkg::S_SCAN_CHK: begin
        if (rel != '0) begin
          // released id found: consumed even when it turns out to be in use
          req.we     = 1'b1;
          req.row    = scan_row;
          req.wdata  = {rel & ~scan_oh, used | scan_oh};
          done_next  = 1'b1;
          state_next = sfid_pkg::S_IDLE;
          if ((used & scan_oh) != '0) begin
            result_id_next = '0;
            status_next    = sfid_pkg::ST_DUP;
          end else begin
            result_id_next = sfid_pkg::to_field({scan_row, scan_bit});
            status_next    = sfid_pkg::ST_OK;
          end
        end else if (scan_row == sfid_pkg::row_t'(sfid_pkg::ROWS - 1)) begin
          if (counter >= sfid_pkg::cnt_t'(sfid_pkg::ID_SPACE)) begin
            done_next      = 1'b1;
            result_id_next = '0;
            status_next    = sfid_pkg::ST_EXHAUSTED;
            state_next     = sfid_pkg::S_IDLE;
          end else begin
            cur_idx_next = sfid_pkg::idx_t'(counter);
            counter_next = counter + sfid_pkg::cnt_t'(1);
            state_next   = sfid_pkg::S_RMW_RD;
          end
        end else begin
          scan_row_next = scan_row + sfid_pkg::row_t'(1);
          state_next    = sfid_pkg::S_SCAN_RD;
        end
      end

      sfid_pkg::S_RMW_RD: begin
        req.rd     = 1'b1;
        req.row    = cur_idx[sfid_pkg::IDX_W-1:sfid_pkg::BIT_W];
        state_next = sfid_pkg::S_RMW_CHK;
      end

      sfid_pkg::S_RMW_CHK: begin
        req.row    = cur_idx[sfid_pkg::IDX_W-1:sfid_pkg::BIT_W];
        done_next  = 1'b1;
        state_next = sfid_pkg::S_IDLE;
        if (op == sfid_pkg::OP_RELEASE) begin
          if ((used & cur_oh) == '0) begin
            result_id_next = '0;
            status_next    = sfid_pkg::ST_NOT_IN_USE;
          end else begin
            req.we         = 1'b1;
            req.wdata      = {rel | cur_oh, used & ~cur_oh};
            result_id_next = sfid_pkg::to_field(cur_idx);
            status_next    = sfid_pkg::ST_OK;
          end
        end else begin
          // claim also drops the id from the released map
          req.we    = 1'b1;
          req.wdata = {rel & ~cur_oh, used | cur_oh};
          if ((used & cur_oh) != '0) begin
            result_id_next = '0;
            status_next    = sfid_pkg::ST_DUP;
          end else begin
            result_id_next = sfid_pkg::to_field(cur_idx);
            status_next    = sfid_pkg::ST_OK;
          end
        end
      end

      default: begin
        state_next = sfid_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    counter <= sfid_pkg::cnt_t'(sfid_pkg::ID_SPACE))
    else $error("id counter ran past the id space");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result beat without a request in flight");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    req.we |-> (state == sfid_pkg::S_SCAN_CHK || state == sfid_pkg::S_RMW_CHK))
    else $error("bitmap written outside an update step");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != sfid_pkg::ST_OK) |-> (result_id == '0))
    else $error("failed request returned a non-zero id");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(counter) |-> ($past(rst) || $past(state) == sfid_pkg::S_SCAN_CHK))
    else $error("id counter moved outside the scan end");
`endif

endmodule

`default_nettype wire

### rtl/sfid_ram.sv
// sfid_ram: generic single-port ram, one access a cycle, registered read data
// no dependencies
`default_nettype none

module sfid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sfid_rowstore.sv
// sfid_rowstore: bitmap row store, ram plus one valid flag a row so reset clears at once
// depends on sfid_pkg and sfid_ram
`default_nettype none

module sfid_rowstore (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sfid_pkg::row_req_t  req,
  output sfid_pkg::row_data_t      rdata
);

  logic [sfid_pkg::ROWS-1:0] row_valid;
  logic                      rd_valid;
  sfid_pkg::row_data_t       ram_rdata;

  sfid_ram #(
    .WIDTH (sfid_pkg::ROW_DATA_W),
    .DEPTH (sfid_pkg::ROWS)
  ) u_ram (
    .clk   (clk),
    .en    (req.rd | req.we),
    .we    (req.we),
    .addr  (req.row),
    .wdata (req.wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (req.we) begin
      row_valid[req.row] <= 1'b1;
    end
  end

  // a row never written reads as all clear
  always_ff @(posedge clk) begin
    if (req.rd && !req.we) begin
      rd_valid <= row_valid[req.row];
    end
  end

  assign rdata = rd_valid ? ram_rdata : '0;

endmodule

`default_nettype wire

### sim/smallest_free_id_allocator_top_test.sv
// smallest_free_id_allocator_top_test: self-checking bench for the id allocator top level
// a queue-fed driver and a done-strobe monitor checked against an in-bench allocation model
// depends on sfid_pkg and smallest_free_id_allocator_top
`timescale 1ns / 100ps

module smallest_free_id_allocator_top_test;
  import sfid_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BEATS = 870;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [ID_SPACE-1:0] in_use;
    logic [ID_SPACE-1:0] released;
    logic [CNT_W-1:0]    next_id;
  } alloc_state_t;

  typedef struct packed {
    id_field_t             id;
    logic [STATUS_W-1:0]   status;
  } alloc_answer_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    id_field_t         id;
    bit                hold_for_drain;
    bit                gaps_allowed;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [FUNC_W-1:0] func = FN_AUTO;
  id_field_t given_id = '0;
  logic busy;
  logic done;
  id_field_t result_id;
  logic [STATUS_W-1:0] status;

  request_t      queued_requests[$];
  alloc_answer_t expected_answers[$];
  alloc_state_t  model_state;
  alloc_state_t  plan_state;
  bit            plan_gaps;
  int            gap_left;
  int            quiet_cycles;
  int            error_count;
  int            fn_count[4];
  int            status_count[4];

  smallest_free_id_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .given_id  (given_id),
    .done      (done),
    .result_id (result_id),
    .status    (status)
  );

  always #1 clk = ~clk;

  // one request against the allocation state; returns the id handed out or freed
  function automatic alloc_answer_t allocate_or_release(inout alloc_state_t st,
                                                        input logic [FUNC_W-1:0] fn,
                                                        input id_field_t id);
    alloc_answer_t ans;
    int cand;
    ans.id     = '0;
    ans.status = ST_OK;
    cand       = -1;
    if (fn == FN_AUTO || (fn == FN_GIVEN && id == '0)) begin
      for (int i = 0; i < ID_SPACE; i++)
        if (cand < 0 && st.released[i]) cand = i;
      if (cand >= 0) begin
        st.released[cand] = 1'b0;
      end else if (st.next_id >= ID_SPACE) begin
        // counter saturates at the top of the space
        st.next_id = CNT_W'(ID_SPACE);
        ans.status = ST_EXHAUSTED;
      end else begin
        cand       = int'(st.next_id);
        st.next_id = st.next_id + 1'b1;
      end
    end else if (fn == FN_GIVEN) begin
      if (int'(id) >= ID_SPACE) begin
        ans.status = ST_EXHAUSTED;
      end else begin
        cand = int'(id);
        st.released[cand] = 1'b0;
      end
    end else if (fn == FN_RELEASE) begin
      if (int'(id) >= ID_SPACE || !st.in_use[id]) begin
        ans.status = ST_NOT_IN_USE;
      end else begin
        st.in_use[id]   = 1'b0;
        st.released[id] = 1'b1;
        ans.id          = id;
      end
    end
    // an automatic candidate stays consumed even when it turns out to be taken
    if (cand >= 0) begin
      if (st.in_use[cand]) begin
        ans.status = ST_DUP;
      end else begin
        st.in_use[cand] = 1'b1;
        ans.id          = id_field_t'(cand);
      end
    end
    return ans;
  endfunction

  // first id in use at or after a random point, wrapping; -1 when the map is empty
  function automatic int find_in_use(input int from);
    int idx;
    for (int i = 0; i < ID_SPACE; i++) begin
      idx = (from + i) % ID_SPACE;
      if (plan_state.in_use[idx]) return idx;
    end
    return -1;
  endfunction

  task automatic queue_request(input logic [FUNC_W-1:0] fn, input id_field_t id,
                               input bit hold);
    request_t req;
    alloc_answer_t unused_ans;
    req.fn             = fn;
    req.id             = id;
    req.hold_for_drain = hold;
    req.gaps_allowed   = plan_gaps;
    queued_requests    = {queued_requests, req};
    unused_ans = allocate_or_release(plan_state, fn, id);
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // request driver: predicts each beat as it is taken, then offers the next one
  always @(posedge clk) begin : request_driver
    request_t nxt;
    alloc_answer_t ans;
    if (rst) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        ans = allocate_or_release(model_state, func, given_id);
        expected_answers = {expected_answers, ans};
        void'(queued_requests.pop_front());
        fn_count[func]++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (queued_requests.size() == 0) begin
          start <= 1'b0;
        end else begin
          nxt = queued_requests[0];
          if (nxt.hold_for_drain && expected_answers.size() != 0) begin
            start <= 1'b0;
          end else if (nxt.gaps_allowed && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 6);
            start <= 1'b0;
          end else begin
            start    <= 1'b1;
            func     <= nxt.fn;
            given_id <= nxt.id;
          end
        end
      end
    end
  end

  // result monitor: every done beat must match the oldest prediction
  always @(posedge clk) begin : result_monitor
    alloc_answer_t exp_ans;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        flag_error($sformatf("unexpected result id %0d status %0d", result_id, status));
      end else begin
        exp_ans = expected_answers.pop_front();
        if (result_id !== exp_ans.id)
          flag_error($sformatf("result_id %0d, expected %0d", result_id, exp_ans.id));
        if (status !== exp_ans.status)
          flag_error($sformatf("status %0d, expected %0d", status, exp_ans.status));
        status_count[exp_ans.status]++;
      end
    end
  end

  // watchdog on cycles with no beat moving in either direction
  always @(posedge clk) begin : stall_watchdog
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int roll;
    bit hold;
    model_state         = '0;
    model_state.next_id = CNT_W'(FIRST_ID);
    plan_state          = model_state;
    plan_gaps           = 1'b1;

    // directed: counter, explicit, duplicates, releases, lowest reuse, unused code
    queue_request(FN_AUTO, 10'h3ff, 1'b0);
    queue_request(FN_AUTO, 10'h000, 1'b0);
    queue_request(FN_GIVEN, 10'd3, 1'b0);
    queue_request(FN_AUTO, 10'd0, 1'b0);      // counter lands on an id already taken
    queue_request(FN_AUTO, 10'd0, 1'b0);
    queue_request(FN_GIVEN, 10'd0, 1'b0);     // explicit zero acts as automatic
    queue_request(FN_GIVEN, 10'h3ff, 1'b0);
    queue_request(FN_GIVEN, 10'h3ff, 1'b0);
    queue_request(FN_RELEASE, 10'h3ff, 1'b0);
    queue_request(FN_RELEASE, 10'h3ff, 1'b0);
    queue_request(FN_RELEASE, 10'd0, 1'b0);
    queue_request(FN_RELEASE, 10'd2, 1'b0);
    queue_request(FN_UNUSED, 10'h3ff, 1'b0);
    queue_request(FN_AUTO, 10'h155, 1'b0);    // smallest released first
    queue_request(FN_AUTO, 10'h2aa, 1'b0);
    queue_request(FN_AUTO, 10'd0, 1'b0);
    queue_request(FN_RELEASE, 10'd1, 1'b1);
    queue_request(FN_RELEASE, 10'd5, 1'b0);
    queue_request(FN_GIVEN, 10'd5, 1'b0);     // explicit grab of a released id
    queue_request(FN_AUTO, 10'd0, 1'b0);
    queue_request(FN_AUTO, 10'd0, 1'b0);
    queue_request(FN_UNUSED, 10'd0, 1'b0);
    queue_request(FN_GIVEN, 10'h200, 1'b0);

    // random: mostly allocate/release traffic on live ids, some noise
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      roll      = $urandom_range(0, 99);
      hold      = (n % 150 == 149);
      plan_gaps = ((n / 100) % 3 != 2) && (n < RANDOM_BEATS - 100);
      if (roll < 40) begin
        queue_request(FN_AUTO, id_field_t'($urandom), hold);
      end else if (roll < 65) begin
        pick = find_in_use($urandom_range(0, ID_SPACE - 1));
        if (pick < 0) queue_request(FN_AUTO, id_field_t'($urandom), hold);
        else queue_request(FN_RELEASE, id_field_t'(pick), hold);
      end else if (roll < 80) begin
        queue_request(FN_GIVEN, id_field_t'($urandom_range(1, ID_SPACE - 1)), hold);
      end else if (roll < 88) begin
        pick = find_in_use($urandom_range(0, ID_SPACE - 1));
        if (pick < 1) pick = $urandom_range(1, ID_SPACE - 1);
        queue_request(FN_GIVEN, id_field_t'(pick), hold);
      end else if (roll < 94) begin
        queue_request(FN_RELEASE, id_field_t'($urandom), hold);
      end else if (roll < 97) begin
        queue_request(FN_UNUSED, id_field_t'($urandom), hold);
      end else begin
        queue_request(FN_GIVEN, '0, hold);
      end
    end

    // closing stretch without gaps: release, reuse and a duplicate grab
    plan_gaps = 1'b0;
    pick = find_in_use($urandom_range(0, ID_SPACE - 1));
    if (pick < 1) pick = 1;
    queue_request(FN_RELEASE, id_field_t'(pick), 1'b0);
    queue_request(FN_AUTO, '0, 1'b0);
    queue_request(FN_GIVEN, id_field_t'(pick), 1'b0);
    queue_request(FN_GIVEN, '0, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (queued_requests.size() != 0 || expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d auto, %0d explicit, %0d release and %0d unused-code requests",
             fn_count[FN_AUTO], fn_count[FN_GIVEN], fn_count[FN_RELEASE], fn_count[FN_UNUSED]);
    $display("answers: %0d ok, %0d duplicate, %0d not in use, %0d exhausted",
             status_count[ST_OK], status_count[ST_DUP], status_count[ST_NOT_IN_USE],
             status_count[ST_EXHAUSTED]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### smallest_free_id_allocator_top.f
rtl/sfid_pkg.sv
rtl/sfid_ram.sv
rtl/sfid_rowstore.sv
rtl/smallest_free_id_allocator_top.sv
sim/smallest_free_id_allocator_top_test.sv
